[rtl/sjf_pkg.sv]
// Package for the shortest-remaining-time scheduler: field widths, item codes,
// the job table word and the sequencer states. No dependencies.
package sjf_pkg;

	localparam int MAX_JOBS_DEF = 16;

	localparam int FUNC_W  = 1;
	localparam int SLOT_W  = 4;
	localparam int BURST_W = 10;
	localparam int TIME_W  = 16;
	localparam int COUNT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b1;

	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrive;
		logic [BURST_W-1:0] remain;
	} job_word_t;

	localparam int JOB_WORD_W = $bits(job_word_t);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_WB    = 5'b01000,
		ST_OUT   = 5'b10000
	} sjf_state_t;

endpackage

[rtl/sjf_ifs.sv]
// Handshake interfaces for the scheduler: request, result and configuration.
// Depends on sjf_pkg for the field widths.
interface sjf_req_if import sjf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [SLOT_W-1:0]  job_slot;
	logic [BURST_W-1:0] burst_len;
	logic [TIME_W-1:0]  arrive_at;

	modport source (output valid, func, job_slot, burst_len, arrive_at, input ready);
	modport sink   (input valid, func, job_slot, burst_len, arrive_at, output ready);
endinterface

interface sjf_rsp_if import sjf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] ran_job;
	logic              idle_tick;
	logic              job_finished;
	logic [TIME_W-1:0] finish_time;
	logic [TIME_W-1:0] turnaround;
	logic [TIME_W-1:0] wait_time;
	logic              all_done;

	modport source (output valid, ran_job, idle_tick, job_finished, finish_time,
		turnaround, wait_time, all_done, input ready);
	modport sink   (input valid, ran_job, idle_tick, job_finished, finish_time,
		turnaround, wait_time, all_done, output ready);
endinterface

interface sjf_cfg_if import sjf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/sjf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sjf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/preemptive_sjf_scheduler_top.sv]
// Top level of the shortest-remaining-time scheduler.
// Depends on sjf_pkg, the interfaces in sjf_ifs and the job table RAM sjf_ram.
//
// The req channel carries load and tick items. A load item writes one job
// entry (burst, arrival, remaining work) and gives no result. A tick item
// scans the first job_count entries of the job table, one entry per cycle
// through the single read port of the table RAM and one shared comparator,
// then writes back the chosen job and advances time. A job_count above
// MAX_JOBS counts as MAX_JOBS. A tick's result passes through the SCAN,
// DRAIN, WB and OUT states (SCAN and DRAIN are skipped when job_count is
// zero) and is registered on rsp; req is not ready while a tick is in progress
// and becomes ready again in the same cycle as the result appears.
// The cfg channel is always ready and sets job_count; it should be written
// only while the block is idle.
// Reset clears time, sets job_count to one and returns the sequencer to idle;
// the job table itself holds no defined contents until loaded.
// A result waits in the output register while rsp is stalled. Load items are
// still taken meanwhile, but the next tick cannot deliver until it drains.
module preemptive_sjf_scheduler_top import sjf_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sjf_req_if.sink   req,
	sjf_rsp_if.source rsp,
	sjf_cfg_if.sink   cfg
);

	localparam int JW   = $clog2(MAX_JOBS);
	localparam int NMAX = (MAX_JOBS < 31) ? MAX_JOBS : 31;

	sjf_state_t         state_q;
	logic [COUNT_W-1:0] jc_q;
	logic [COUNT_W-1:0] n_act;
	logic [COUNT_W-1:0] idx_q;
	logic [COUNT_W-1:0] idx_s1;
	logic               vld_s1;
	logic               found_q;
	logic [COUNT_W-1:0] best_q;
	job_word_t          best_word_q;
	logic [1:0]         cnt_q;
	logic [TIME_W-1:0]  now_q;

	logic               ram_we;
	logic [JW-1:0]      ram_waddr;
	job_word_t          ram_wdata;
	job_word_t          ram_rdata;
	logic [JOB_WORD_W-1:0] ram_rbits;

	logic               req_acc;
	logic               has_work;
	logic               take;
	logic               fin;
	logic [TIME_W-1:0]  ft;
	logic [TIME_W-1:0]  tat;
	logic [TIME_W-1:0]  wt;

	logic [SLOT_W-1:0]  res_job_q;
	logic               res_idle_q;
	logic               res_fin_q;
	logic [TIME_W-1:0]  res_ft_q;
	logic [TIME_W-1:0]  res_tat_q;
	logic [TIME_W-1:0]  res_wt_q;
	logic               res_all_q;
	logic               out_load;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign n_act = (jc_q > COUNT_W'(NMAX)) ? COUNT_W'(NMAX) : jc_q;

	assign ram_rdata = job_word_t'(ram_rbits);
	assign has_work  = (ram_rdata.remain != '0);
	assign take      = vld_s1 && has_work && (ram_rdata.arrive <= now_q)
		&& (!found_q || (ram_rdata.remain < best_word_q.remain));

	assign fin = found_q && (best_word_q.remain == BURST_W'(1));
	assign ft  = now_q + TIME_W'(1);
	assign tat = ft - best_word_q.arrive;
	assign wt  = tat - TIME_W'(best_word_q.burst);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = JW'(req.job_slot);
		ram_wdata = '{burst: req.burst_len, arrive: req.arrive_at, remain: req.burst_len};
		if (req_acc && (req.func == FUNC_LOAD) && (32'(req.job_slot) < MAX_JOBS)) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_WB) && found_q) begin
			ram_we    = 1'b1;
			ram_waddr = JW'(best_q);
			ram_wdata = best_word_q;
			ram_wdata.remain = best_word_q.remain - BURST_W'(1);
		end
	end

	sjf_ram #(
		.WIDTH (JOB_WORD_W),
		.DEPTH (MAX_JOBS)
	) u_job_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (JW'(idx_q)),
		.rdata (ram_rbits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			jc_q    <= COUNT_W'(1);
			idx_q   <= '0;
			idx_s1  <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			best_q  <= '0;
			cnt_q   <= '0;
			now_q   <= '0;
		end else begin
			if (cfg.valid) begin
				jc_q <= cfg.data;
			end
			if (vld_s1) begin
				if (take) begin
					found_q <= 1'b1;
					best_q  <= idx_s1;
				end
				if (has_work && (cnt_q != 2'd2)) begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (req.func == FUNC_TICK)) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						idx_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= (n_act == '0) ? ST_WB : ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= 1'b1;
					idx_s1 <= idx_q;
					idx_q  <= idx_q + COUNT_W'(1);
					if (idx_q == n_act - COUNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					vld_s1  <= 1'b0;
					state_q <= ST_WB;
				end
				ST_WB: begin
					now_q   <= ft;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_word_q <= ram_rdata;
		end
		if (state_q == ST_WB) begin
			res_job_q  <= found_q ? best_q[SLOT_W-1:0] : '0;
			res_idle_q <= !found_q;
			res_fin_q  <= fin;
			res_ft_q   <= fin ? ft : '0;
			res_tat_q  <= fin ? tat : '0;
			res_wt_q   <= fin ? wt : '0;
			res_all_q  <= (cnt_q == 2'd0) || ((cnt_q == 2'd1) && fin);
		end
	end

	assign out_load = (state_q == ST_OUT) && (!rsp.valid || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (out_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.ran_job      <= res_job_q;
			rsp.idle_tick    <= res_idle_q;
			rsp.job_finished <= res_fin_q;
			rsp.finish_time  <= res_ft_q;
			rsp.turnaround   <= res_tat_q;
			rsp.wait_time    <= res_wt_q;
			rsp.all_done     <= res_all_q;
		end
	end

endmodule

[sim/sjf_sched_checker.sv]
// Scoreboard for the shortest-remaining-time scheduler: it mirrors the job table,
// works out the outcome of every tick item and compares it with the rsp channel.
// Depends on sjf_pkg and the interfaces in sjf_ifs.
module sjf_sched_checker import sjf_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sjf_req_if   req,
	sjf_rsp_if   rsp,
	sjf_cfg_if   cfg,
	output int   errors,
	output int   outstanding,
	output int   results_checked,
	output int   completions
);

	typedef struct packed {
		logic [SLOT_W-1:0] ran_job;
		logic              idle_tick;
		logic              job_finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
		logic              all_done;
	} tick_outcome_t;

	logic [BURST_W-1:0] burst_mem  [MAX_JOBS];
	logic [TIME_W-1:0]  arrive_mem [MAX_JOBS];
	logic [BURST_W-1:0] remain_mem [MAX_JOBS];
	logic               done_mem   [MAX_JOBS];
	logic [TIME_W-1:0]  sched_now;
	logic [COUNT_W-1:0] job_limit;
	tick_outcome_t      tick_outcomes_q [$];

	function automatic int active_jobs();
		return (int'(job_limit) > MAX_JOBS) ? MAX_JOBS : int'(job_limit);
	endfunction

	task automatic predict_tick(output tick_outcome_t o);
		int n;
		int best;
		bit found;
		o = '0;
		n = active_jobs();
		best = 0;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!done_mem[i] && remain_mem[i] != '0 && arrive_mem[i] <= sched_now) begin
				if (!found || remain_mem[i] < remain_mem[best]) begin
					best = i;
					found = 1'b1;
				end
			end
		end
		sched_now = sched_now + 1'b1;
		o.idle_tick = !found;
		if (found) begin
			o.ran_job = SLOT_W'(best);
			remain_mem[best] = remain_mem[best] - 1'b1;
			if (remain_mem[best] == '0) begin
				done_mem[best] = 1'b1;
				o.job_finished = 1'b1;
				o.finish_time = sched_now;
				o.turnaround = sched_now - arrive_mem[best];
				o.wait_time = o.turnaround - TIME_W'(burst_mem[best]);
			end
		end
		o.all_done = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (!done_mem[i] && remain_mem[i] != '0) begin
				o.all_done = 1'b0;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
		input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_outcome_t want;
		tick_outcome_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS; i++) begin
				burst_mem[i] = '0;
				arrive_mem[i] = '0;
				remain_mem[i] = '0;
				done_mem[i] = 1'b0;
			end
			sched_now = '0;
			job_limit = COUNT_W'(1);
			tick_outcomes_q.delete();
			outstanding = 0;
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				job_limit = cfg.data;
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				if (req.func == FUNC_LOAD) begin
					if (int'(req.job_slot) < MAX_JOBS) begin
						burst_mem[req.job_slot] = req.burst_len;
						arrive_mem[req.job_slot] = req.arrive_at;
						remain_mem[req.job_slot] = req.burst_len;
						done_mem[req.job_slot] = 1'b0;
					end
				end else begin
					predict_tick(want);
					tick_outcomes_q.push_back(want);
				end
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.ran_job = rsp.ran_job;
				got.idle_tick = rsp.idle_tick;
				got.job_finished = rsp.job_finished;
				got.finish_time = rsp.finish_time;
				got.turnaround = rsp.turnaround;
				got.wait_time = rsp.wait_time;
				got.all_done = rsp.all_done;
				if (tick_outcomes_q.size() == 0) begin
					$error("Result item arrived with no tick outstanding.");
					errors++;
				end else begin
					want = tick_outcomes_q.pop_front();
					check_field("ran_job", TIME_W'(want.ran_job), TIME_W'(got.ran_job));
					check_field("idle_tick", TIME_W'(want.idle_tick), TIME_W'(got.idle_tick));
					check_field("job_finished", TIME_W'(want.job_finished),
						TIME_W'(got.job_finished));
					check_field("finish_time", want.finish_time, got.finish_time);
					check_field("turnaround", want.turnaround, got.turnaround);
					check_field("wait_time", want.wait_time, got.wait_time);
					check_field("all_done", TIME_W'(want.all_done), TIME_W'(got.all_done));
					results_checked++;
					if (want.job_finished) begin
						completions++;
					end
				end
			end
			outstanding = tick_outcomes_q.size();
		end
	end

endmodule

[sim/preemptive_sjf_scheduler_top_tb.sv]
// Top of the scheduler testbench: clock, reset, stimulus on req and cfg, random
// back-pressure on rsp, a watchdog and the verdict.
// Depends on sjf_pkg, sjf_ifs, the scheduler RTL and sjf_sched_checker.
module preemptive_sjf_scheduler_top_tb;
	import sjf_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT    = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sjf_req_if req_ch ();
	sjf_rsp_if rsp_ch ();
	sjf_cfg_if cfg_ch ();

	int fail_count;
	int pending;
	int results_checked;
	int completions;
	int loads_sent;
	int ticks_sent;
	int settings_made;
	int idle_cycles;
	logic [TIME_W-1:0] sched_clock;
	bit gaps_on = 1'b1;
	bit rsp_gaps_on = 1'b1;
	bit rsp_hold = 1'b0;

	preemptive_sjf_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	sjf_sched_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch),
		.errors(fail_count),
		.outstanding(pending),
		.results_checked(results_checked),
		.completions(completions)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(input bit on);
		int r;
		if (!on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [BURST_W-1:0] pick_burst();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return BURST_W'($urandom_range(1, 8));
		end
		if (r < 93) begin
			return BURST_W'($urandom_range(9, 40));
		end
		if (r < 96) begin
			return '0;
		end
		return BURST_W'($urandom_range(41, 1023));
	endfunction

	function automatic logic [TIME_W-1:0] pick_arrival();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return sched_clock + TIME_W'($urandom_range(0, 10));
		end
		if (r < 88) begin
			return sched_clock - TIME_W'($urandom_range(0, 60));
		end
		return TIME_W'($urandom);
	endfunction

	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] slot,
		input logic [BURST_W-1:0] burst, input logic [TIME_W-1:0] arrive);
		int gap;
		gap = pick_gap(gaps_on);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.job_slot <= slot;
		req_ch.burst_len <= burst;
		req_ch.arrive_at <= arrive;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
		if (f == FUNC_TICK) begin
			ticks_sent++;
			sched_clock = sched_clock + 1'b1;
		end else begin
			loads_sent++;
		end
	endtask

	task automatic send_tick();
		send_req(FUNC_TICK, SLOT_W'($urandom), BURST_W'($urandom), TIME_W'($urandom));
	endtask

	task automatic configure_jobs(input logic [COUNT_W-1:0] count);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= count;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_made++;
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] count, input bit squeeze);
		int active;
		int n_items;
		configure_jobs(count);
		if (squeeze) begin
			rsp_hold = 1'b1;
		end
		active = (int'(count) > MAX_JOBS_DEF) ? MAX_JOBS_DEF : int'(count);
		n_items = active + $urandom_range(25, 45);
		for (int s = 0; s < active; s++) begin
			send_req(FUNC_LOAD, SLOT_W'(s), pick_burst(), pick_arrival());
		end
		for (int k = active; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 12) begin
				send_req(FUNC_LOAD, SLOT_W'($urandom_range(0, 15)), pick_burst(),
					pick_arrival());
			end else begin
				send_tick();
			end
		end
	endtask

	initial begin
		int stall_left;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rsp_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_hold = 1'b0;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = pick_gap(rsp_gaps_on);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles.", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [COUNT_W-1:0] cnt;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_LOAD;
		req_ch.job_slot = '0;
		req_ch.burst_len = '0;
		req_ch.arrive_at = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		sched_clock = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure_jobs(COUNT_W'(16));
		send_req(FUNC_LOAD, SLOT_W'(0), BURST_W'(2), TIME_W'(0));
		send_req(FUNC_LOAD, SLOT_W'(1), BURST_W'(1), TIME_W'(0));
		send_req(FUNC_LOAD, SLOT_W'(2), BURST_W'(2), TIME_W'(0));
		send_req(FUNC_LOAD, SLOT_W'(3), BURST_W'(1023), TIME_W'(0));
		send_req(FUNC_LOAD, SLOT_W'(4), BURST_W'(0), TIME_W'(0));
		send_req(FUNC_LOAD, SLOT_W'(5), BURST_W'(1), TIME_W'(3));
		for (int s = 6; s < 15; s++) begin
			send_req(FUNC_LOAD, SLOT_W'(s), BURST_W'(7), TIME_W'(40000));
		end
		send_req(FUNC_LOAD, SLOT_W'(15), BURST_W'(1), TIME_W'(65535));
		repeat (10) send_tick();

		run_phase(COUNT_W'(1), 1'b0);
		run_phase(COUNT_W'(0), 1'b0);
		run_phase(COUNT_W'(31), 1'b0);
		run_phase(COUNT_W'(16), 1'b1);

		for (int p = 0; p < 10; p++) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			rsp_gaps_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: begin
					cnt = COUNT_W'($urandom_range(2, 15));
				end
				1: begin
					cnt = COUNT_W'(16);
				end
				2: begin
					cnt = COUNT_W'($urandom_range(17, 31));
				end
				default: begin
					cnt = COUNT_W'($urandom_range(1, 16));
				end
			endcase
			run_phase(cnt, 1'b0);
		end

		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Covered %0d loads and %0d ticks over %0d job_count settings.",
			loads_sent, ticks_sent, settings_made);
		$display("Checked %0d tick results, %0d of them job completions.",
			results_checked, completions);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/sjf_pkg.sv
rtl/sjf_ifs.sv
rtl/sjf_ram.sv
rtl/preemptive_sjf_scheduler_top.sv
sim/sjf_sched_checker.sv
sim/preemptive_sjf_scheduler_top_tb.sv
